// ===== hw/rtl/rawq_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants of the resource allocator with wait queue
// no dependencies; used by every module under hw/rtl
package rawq_pkg;

	localparam int NUM_RES = 16;
	localparam int NUM_REQ = 256;
	localparam int RES_W = 5;
	localparam int REQ_W = 8;
	localparam int FREE_IDX_W = $clog2(NUM_RES);
	localparam int FREE_FILL_W = $clog2(NUM_RES + 1);
	localparam int WAIT_FILL_W = $clog2(NUM_REQ + 1);

	typedef enum logic {
		CMD_REQ = 1'b0,
		CMD_REL = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		K_GRANT = 2'd0,
		K_CANCEL = 2'd1,
		K_ERROR = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_HOLD = 2'd1,
		ST_WAIT = 2'd2,
		ST_CANC = 2'd3
	} hold_state_t;

	typedef struct packed {
		hold_state_t state;
		logic [RES_W-1:0] res;
	} stat_t;

	typedef struct packed {
		cmd_t cmd;
		logic [REQ_W-1:0] requester;
	} req_t;

	typedef struct packed {
		kind_t kind;
		logic [REQ_W-1:0] grantee;
		logic [RES_W-1:0] resource;
	} rsp_t;

	typedef struct packed {
		logic load;
		logic pop;
		logic push;
	} fl_ctl_t;

	typedef struct packed {
		logic push;
		logic pop;
	} wq_ctl_t;

	typedef struct packed {
		logic empty;
		logic full;
	} wq_stat_t;

endpackage

// ===== hw/rtl/rawq_status_table.sv =====
`timescale 1ns / 1ps
// per-requester status table: synchronous ram with registered read
// uses rawq_pkg; per-entry valid bits make unwritten entries read as idle
module rawq_status_table (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        rd_en,
	input  logic [rawq_pkg::REQ_W-1:0]  rd_addr,
	output rawq_pkg::stat_t             rd_data,
	input  logic                        wr_en,
	input  logic [rawq_pkg::REQ_W-1:0]  wr_addr,
	input  rawq_pkg::stat_t             wr_data
);

	rawq_pkg::stat_t mem [rawq_pkg::NUM_REQ];
	rawq_pkg::stat_t mem_q;
	logic [rawq_pkg::NUM_REQ-1:0] valid_q;
	logic rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			mem_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= valid_q[rd_addr];
			end
		end
	end

	// never-written entries read back as idle with no resource
	always_comb begin
		if (rd_vld_q) begin
			rd_data = mem_q;
		end else begin
			rd_data.state = rawq_pkg::ST_IDLE;
			rd_data.res = '0;
		end
	end

endmodule

// ===== hw/rtl/rawq_wait_queue.sv =====
`timescale 1ns / 1ps
// fifo of waiting requester ids in a synchronous ram, registered read on pop
// uses rawq_pkg; the ram itself has no reset, pointers do
module rawq_wait_queue (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rawq_pkg::wq_ctl_t           ctl,
	input  logic [rawq_pkg::REQ_W-1:0]  push_data,
	output logic [rawq_pkg::REQ_W-1:0]  pop_data,
	output rawq_pkg::wq_stat_t          stat
);

	logic [rawq_pkg::REQ_W-1:0] mem [rawq_pkg::NUM_REQ];
	logic [rawq_pkg::REQ_W-1:0] head_q;
	logic [rawq_pkg::WAIT_FILL_W-1:0] fill_q;
	logic [rawq_pkg::REQ_W-1:0] rd_q;
	logic [rawq_pkg::REQ_W-1:0] tail;

	assign tail = head_q + fill_q[rawq_pkg::REQ_W-1:0];

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			mem[tail] <= push_data;
		end
		if (ctl.pop) begin
			rd_q <= mem[head_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			fill_q <= '0;
		end else if (ctl.pop) begin
			head_q <= head_q + rawq_pkg::REQ_W'(1);
			fill_q <= fill_q - rawq_pkg::WAIT_FILL_W'(1);
		end else if (ctl.push) begin
			fill_q <= fill_q + rawq_pkg::WAIT_FILL_W'(1);
		end
	end

	assign pop_data = rd_q;
	assign stat.empty = (fill_q == '0);
	assign stat.full = (fill_q == rawq_pkg::WAIT_FILL_W'(rawq_pkg::NUM_REQ));

endmodule

// ===== hw/rtl/rawq_free_list.sv =====
`timescale 1ns / 1ps
// fifo of free resource numbers held in registers, reloadable with 1..count
// uses rawq_pkg
module rawq_free_list (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rawq_pkg::fl_ctl_t           ctl,
	input  logic [rawq_pkg::RES_W-1:0]  load_count,
	input  logic [rawq_pkg::RES_W-1:0]  push_res,
	output logic [rawq_pkg::RES_W-1:0]  head_res,
	output logic                        empty
);

	logic [rawq_pkg::RES_W-1:0] list_q [rawq_pkg::NUM_RES];
	logic [rawq_pkg::FREE_IDX_W-1:0] head_q;
	logic [rawq_pkg::FREE_FILL_W-1:0] fill_q;
	logic [rawq_pkg::FREE_FILL_W-1:0] count;
	logic [rawq_pkg::FREE_IDX_W-1:0] tail;

	// written count saturates to 1..NUM_RES
	always_comb begin
		if (load_count == '0) begin
			count = rawq_pkg::FREE_FILL_W'(1);
		end else if (rawq_pkg::FREE_FILL_W'(load_count) >
				rawq_pkg::FREE_FILL_W'(rawq_pkg::NUM_RES)) begin
			count = rawq_pkg::FREE_FILL_W'(rawq_pkg::NUM_RES);
		end else begin
			count = rawq_pkg::FREE_FILL_W'(load_count);
		end
	end

	assign tail = head_q + fill_q[rawq_pkg::FREE_IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < rawq_pkg::NUM_RES; i++) begin
				list_q[i] <= rawq_pkg::RES_W'(i + 1);
			end
			head_q <= '0;
			fill_q <= rawq_pkg::FREE_FILL_W'(rawq_pkg::NUM_RES);
		end else if (ctl.load) begin
			for (int i = 0; i < rawq_pkg::NUM_RES; i++) begin
				list_q[i] <= (rawq_pkg::FREE_FILL_W'(i) < count) ?
					rawq_pkg::RES_W'(i + 1) : '0;
			end
			head_q <= '0;
			fill_q <= count;
		end else if (ctl.pop) begin
			head_q <= head_q + rawq_pkg::FREE_IDX_W'(1);
			fill_q <= fill_q - rawq_pkg::FREE_FILL_W'(1);
		end else if (ctl.push &&
				fill_q < rawq_pkg::FREE_FILL_W'(rawq_pkg::NUM_RES)) begin
			// a return to a full list is dropped
			list_q[tail] <= push_res;
			fill_q <= fill_q + rawq_pkg::FREE_FILL_W'(1);
		end
	end

	assign head_res = list_q[head_q];
	assign empty = (fill_q == '0);

endmodule

// ===== hw/rtl/resource_allocator_with_wait_queue_top.sv =====
`timescale 1ns / 1ps
// Resource allocator with a fifo free list and a fifo wait queue.
// Input channel in_valid/in_stall/in_data carries one request: cmd (request
// or release) and the requester id. Output channel out_valid/out_stall/
// out_data carries at most one result per request: grant, wait cancelled,
// or error (protocol error or full wait queue), with the requester and the resource number.
// cfg_we/cfg_wdata writes the resource count (saturated to 1..16) and
// reloads the free list with 1..count; write it only while the block is idle.
// The status entry is read at the accepting edge; in S_DECIDE the result is
// registered on the output once the output register is free. A release by
// a holder with waiters queued instead walks the wait queue entry by entry
// (queue ram read, then status ram read), skipping cancelled waiters.
// A new request is taken only after the last one is through, as set by the
// read-modify-write of the status ram and, for a holder release, the queue walk.
// in_stall is high while a request is being worked on. A finished result
// waits in the output register while out_stall is high; the next request is
// still accepted and is held back only where it has a result to deliver.
// Reset (arst_n, asynchronous) makes every requester idle at once through
// per-entry valid bits, empties the wait queue and loads resources 1..16.
module resource_allocator_with_wait_queue_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  rawq_pkg::req_t              in_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output rawq_pkg::rsp_t              out_data,
	input  logic                        cfg_we,
	input  logic [rawq_pkg::RES_W-1:0]  cfg_wdata
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_DECIDE,
		S_SREAD,
		S_CHECK
	} fsm_t;

	fsm_t state_q, state_d;
	rawq_pkg::cmd_t cmd_q;
	logic [rawq_pkg::REQ_W-1:0] rid_q;
	logic [rawq_pkg::RES_W-1:0] res_q;
	logic out_valid_q;
	rawq_pkg::rsp_t out_data_q;

	logic st_rd_en;
	logic [rawq_pkg::REQ_W-1:0] st_rd_addr;
	rawq_pkg::stat_t st_rd_data;
	logic st_wr_en;
	logic [rawq_pkg::REQ_W-1:0] st_wr_addr;
	rawq_pkg::stat_t st_wr_data;

	rawq_pkg::fl_ctl_t fl_ctl;
	logic [rawq_pkg::RES_W-1:0] fl_push_res;
	logic [rawq_pkg::RES_W-1:0] fl_head_res;
	logic fl_empty;

	rawq_pkg::wq_ctl_t wq_ctl;
	logic [rawq_pkg::REQ_W-1:0] wq_pop_data;
	rawq_pkg::wq_stat_t wq_stat;

	logic accept;
	logic can_emit;
	logic emit;
	rawq_pkg::rsp_t emit_data;

	rawq_status_table u_status (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (st_rd_en),
		.rd_addr (st_rd_addr),
		.rd_data (st_rd_data),
		.wr_en   (st_wr_en),
		.wr_addr (st_wr_addr),
		.wr_data (st_wr_data)
	);

	rawq_wait_queue u_wait (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (wq_ctl),
		.push_data (rid_q),
		.pop_data  (wq_pop_data),
		.stat      (wq_stat)
	);

	rawq_free_list u_free (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (fl_ctl),
		.load_count (cfg_wdata),
		.push_res   (fl_push_res),
		.head_res   (fl_head_res),
		.empty      (fl_empty)
	);

	assign in_stall = (state_q != S_IDLE);
	assign accept = in_valid && !in_stall;
	assign can_emit = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		st_rd_en = 1'b0;
		st_rd_addr = in_data.requester;
		st_wr_en = 1'b0;
		st_wr_addr = rid_q;
		st_wr_data.state = rawq_pkg::ST_IDLE;
		st_wr_data.res = '0;
		fl_ctl.load = cfg_we;
		fl_ctl.pop = 1'b0;
		fl_ctl.push = 1'b0;
		fl_push_res = st_rd_data.res;
		wq_ctl.push = 1'b0;
		wq_ctl.pop = 1'b0;
		emit = 1'b0;
		emit_data.kind = rawq_pkg::K_ERROR;
		emit_data.grantee = rid_q;
		emit_data.resource = '0;

		case (state_q)
			S_IDLE: begin
				if (accept) begin
					st_rd_en = 1'b1;
					state_d = S_DECIDE;
				end
			end

			S_DECIDE: begin
				if (cmd_q == rawq_pkg::CMD_REQ) begin
					if (st_rd_data.state != rawq_pkg::ST_IDLE) begin
						if (can_emit) begin
							emit = 1'b1;
							state_d = S_IDLE;
						end
					end else if (!fl_empty) begin
						if (can_emit) begin
							emit = 1'b1;
							emit_data.kind = rawq_pkg::K_GRANT;
							emit_data.resource = fl_head_res;
							fl_ctl.pop = 1'b1;
							st_wr_en = 1'b1;
							st_wr_data.state = rawq_pkg::ST_HOLD;
							st_wr_data.res = fl_head_res;
							state_d = S_IDLE;
						end
					end else if (wq_stat.full) begin
						if (can_emit) begin
							emit = 1'b1;
							state_d = S_IDLE;
						end
					end else begin
						wq_ctl.push = 1'b1;
						st_wr_en = 1'b1;
						st_wr_data.state = rawq_pkg::ST_WAIT;
						state_d = S_IDLE;
					end
				end else begin
					if (st_rd_data.state == rawq_pkg::ST_WAIT) begin
						if (can_emit) begin
							emit = 1'b1;
							emit_data.kind = rawq_pkg::K_CANCEL;
							st_wr_en = 1'b1;
							st_wr_data.state = rawq_pkg::ST_CANC;
							st_wr_data.res = st_rd_data.res;
							state_d = S_IDLE;
						end
					end else if (st_rd_data.state != rawq_pkg::ST_HOLD) begin
						if (can_emit) begin
							emit = 1'b1;
							state_d = S_IDLE;
						end
					end else begin
						// holder gives back: hand to a waiter or to the free list
						st_wr_en = 1'b1;
						if (!wq_stat.empty) begin
							wq_ctl.pop = 1'b1;
							state_d = S_SREAD;
						end else begin
							fl_ctl.push = 1'b1;
							state_d = S_IDLE;
						end
					end
				end
			end

			S_SREAD: begin
				st_rd_en = 1'b1;
				st_rd_addr = wq_pop_data;
				state_d = S_CHECK;
			end

			S_CHECK: begin
				st_wr_addr = wq_pop_data;
				fl_push_res = res_q;
				if (st_rd_data.state == rawq_pkg::ST_CANC) begin
					// cancelled waiter is dropped and goes idle
					st_wr_en = 1'b1;
					if (!wq_stat.empty) begin
						wq_ctl.pop = 1'b1;
						state_d = S_SREAD;
					end else begin
						fl_ctl.push = 1'b1;
						state_d = S_IDLE;
					end
				end else if (can_emit) begin
					emit = 1'b1;
					emit_data.kind = rawq_pkg::K_GRANT;
					emit_data.grantee = wq_pop_data;
					emit_data.resource = res_q;
					st_wr_en = 1'b1;
					st_wr_data.state = rawq_pkg::ST_HOLD;
					st_wr_data.res = res_q;
					state_d = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= in_data.cmd;
			rid_q <= in_data.requester;
		end
		if (state_q == S_DECIDE) begin
			res_q <= st_rd_data.res;
		end
		if (emit) begin
			out_data_q <= emit_data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// testbench for resource_allocator_with_wait_queue_top: directed and random requests
// checked against an in-bench allocator predictor; depends on rawq_pkg and the top rtl
module tb_top;

	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 600;
	localparam int PHASE_ITEMS = 200;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	rawq_pkg::req_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	rawq_pkg::rsp_t out_data;
	logic cfg_we = 1'b0;
	logic [rawq_pkg::RES_W-1:0] cfg_wdata = '0;

	// predictor state
	rawq_pkg::hold_state_t holder_state [rawq_pkg::NUM_REQ];
	logic [rawq_pkg::RES_W-1:0] holder_res [rawq_pkg::NUM_REQ];
	logic [rawq_pkg::RES_W-1:0] free_slots [rawq_pkg::NUM_RES];
	int free_head;
	int free_fill;
	logic [rawq_pkg::REQ_W-1:0] waiters [rawq_pkg::NUM_REQ];
	int wait_head;
	int wait_fill;

	rawq_pkg::req_t pending_reqs [$];
	rawq_pkg::rsp_t pending_outcomes [$];
	rawq_pkg::rsp_t want_rsp;
	int mismatch_count = 0;
	int cycle_count = 0;
	int idle_left = 0;
	int stall_left = 0;
	bit tx_burst = 1'b0;
	bit rx_burst = 1'b0;

	resource_allocator_with_wait_queue_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("resource_allocator_with_wait_queue_top verification failed");
			$finish;
		end
	end

	task automatic report_mismatch(string msg);
		$display("mismatch at cycle %0d: %s", cycle_count, msg);
		mismatch_count++;
	endtask

	function automatic void reload_free(int count);
		free_head = 0;
		free_fill = count;
		for (int i = 0; i < rawq_pkg::NUM_RES; i++)
			free_slots[i] = (i < count) ? rawq_pkg::RES_W'(i + 1) : '0;
	endfunction

	// work out the outcome of one accepted request
	function automatic void allocate_step(rawq_pkg::req_t q);
		int r;
		int w;
		rawq_pkg::rsp_t o;
		logic [rawq_pkg::RES_W-1:0] res;
		r = q.requester;
		o = '0;
		o.grantee = q.requester;
		if (q.cmd == rawq_pkg::CMD_REQ) begin
			if (holder_state[r] != rawq_pkg::ST_IDLE) begin
				o.kind = rawq_pkg::K_ERROR;
				pending_outcomes.push_back(o);
			end else if (free_fill > 0) begin
				res = free_slots[free_head];
				free_head = (free_head + 1) % rawq_pkg::NUM_RES;
				free_fill--;
				holder_state[r] = rawq_pkg::ST_HOLD;
				holder_res[r] = res;
				o.kind = rawq_pkg::K_GRANT;
				o.resource = res;
				pending_outcomes.push_back(o);
			end else if (wait_fill >= rawq_pkg::NUM_REQ) begin
				o.kind = rawq_pkg::K_ERROR;
				pending_outcomes.push_back(o);
			end else begin
				waiters[(wait_head + wait_fill) % rawq_pkg::NUM_REQ] = q.requester;
				wait_fill++;
				holder_state[r] = rawq_pkg::ST_WAIT;
				holder_res[r] = '0;
			end
			return;
		end
		if (holder_state[r] == rawq_pkg::ST_WAIT) begin
			holder_state[r] = rawq_pkg::ST_CANC;
			o.kind = rawq_pkg::K_CANCEL;
			pending_outcomes.push_back(o);
			return;
		end
		if (holder_state[r] != rawq_pkg::ST_HOLD) begin
			o.kind = rawq_pkg::K_ERROR;
			pending_outcomes.push_back(o);
			return;
		end
		res = holder_res[r];
		holder_state[r] = rawq_pkg::ST_IDLE;
		holder_res[r] = '0;
		// hand over to the oldest live waiter, dropping cancelled entries
		while (wait_fill > 0) begin
			w = waiters[wait_head];
			wait_head = (wait_head + 1) % rawq_pkg::NUM_REQ;
			wait_fill--;
			if (holder_state[w] == rawq_pkg::ST_CANC) begin
				holder_state[w] = rawq_pkg::ST_IDLE;
			end else begin
				holder_state[w] = rawq_pkg::ST_HOLD;
				holder_res[w] = res;
				o.kind = rawq_pkg::K_GRANT;
				o.grantee = rawq_pkg::REQ_W'(w);
				o.resource = res;
				pending_outcomes.push_back(o);
				return;
			end
		end
		// a full free list drops the returned resource
		if (free_fill < rawq_pkg::NUM_RES) begin
			free_slots[(free_head + free_fill) % rawq_pkg::NUM_RES] = res;
			free_fill++;
		end
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			idle_left = 0;
		end else begin
			if (in_valid && !in_stall) begin
				allocate_step(in_data);
				if ($urandom_range(0, 39) == 0)
					tx_burst = !tx_burst;
				idle_left = tx_burst ? 0 : $urandom_range(0, 4);
			end
			if (!in_valid || !in_stall) begin
				if (idle_left > 0) begin
					idle_left--;
					in_valid <= 1'b0;
				end else if (pending_reqs.size() != 0) begin
					in_data <= pending_reqs.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and receiver stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pending_outcomes.size() == 0) begin
					report_mismatch($sformatf("unexpected result kind %0d grantee %0d",
						out_data.kind, out_data.grantee));
				end else begin
					want_rsp = pending_outcomes.pop_front();
					if (out_data.kind !== want_rsp.kind)
						report_mismatch($sformatf("kind %0d, expected %0d (grantee %0d)",
							out_data.kind, want_rsp.kind, want_rsp.grantee));
					if (out_data.grantee !== want_rsp.grantee)
						report_mismatch($sformatf("grantee %0d, expected %0d",
							out_data.grantee, want_rsp.grantee));
					if (out_data.resource !== want_rsp.resource)
						report_mismatch($sformatf("resource %0d, expected %0d (grantee %0d)",
							out_data.resource, want_rsp.resource, want_rsp.grantee));
				end
				if ($urandom_range(0, 39) == 0)
					rx_burst = !rx_burst;
				stall_left = rx_burst ? 0 : $urandom_range(0, 4);
			end
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic push_req(rawq_pkg::cmd_t c, int r);
		rawq_pkg::req_t q;
		q.cmd = c;
		q.requester = rawq_pkg::REQ_W'(r);
		pending_reqs.push_back(q);
	endtask

	// hold the sender until every outstanding request has delivered its result
	task automatic drain_all();
		while (pending_reqs.size() != 0 || in_valid || pending_outcomes.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic load_count(logic [rawq_pkg::RES_W-1:0] value);
		int c;
		drain_all();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		c = value;
		if (c < 1)
			c = 1;
		if (c > rawq_pkg::NUM_RES)
			c = rawq_pkg::NUM_RES;
		reload_free(c);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// mostly legal traffic from a small pool of requesters, some noise over the full range
	task automatic random_phase(int n);
		int pool_base;
		int pool_size;
		int r;
		rawq_pkg::req_t q;
		pool_base = $urandom_range(0, rawq_pkg::NUM_REQ - 1);
		pool_size = $urandom_range(3, 40);
		for (int i = 0; i < n; i++) begin
			while (pending_reqs.size() >= 2)
				@(negedge clk);
			if ($urandom_range(0, 99) < 12) begin
				q.cmd = rawq_pkg::cmd_t'($urandom_range(0, 1));
				q.requester = rawq_pkg::REQ_W'($urandom_range(0, rawq_pkg::NUM_REQ - 1));
			end else begin
				r = 0;
				for (int t = 0; t < 6; t++) begin
					r = (pool_base + $urandom_range(0, pool_size - 1)) % rawq_pkg::NUM_REQ;
					if (holder_state[r] == rawq_pkg::ST_IDLE ||
							holder_state[r] == rawq_pkg::ST_HOLD)
						break;
					if (holder_state[r] == rawq_pkg::ST_WAIT && $urandom_range(0, 3) == 0)
						break;
				end
				q.requester = rawq_pkg::REQ_W'(r);
				q.cmd = (holder_state[r] == rawq_pkg::ST_IDLE) ?
					rawq_pkg::CMD_REQ : rawq_pkg::CMD_REL;
			end
			pending_reqs.push_back(q);
		end
	endtask

	initial begin
		for (int i = 0; i < rawq_pkg::NUM_REQ; i++) begin
			holder_state[i] = rawq_pkg::ST_IDLE;
			holder_res[i] = '0;
			waiters[i] = '0;
		end
		reload_free(rawq_pkg::NUM_RES);
		wait_head = 0;
		wait_fill = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// zero saturates to a single resource
		load_count(5'd0);
		push_req(rawq_pkg::CMD_REQ, 0);
		push_req(rawq_pkg::CMD_REQ, 255);
		push_req(rawq_pkg::CMD_REQ, 8'h55);
		push_req(rawq_pkg::CMD_REQ, 0);
		push_req(rawq_pkg::CMD_REQ, 255);
		push_req(rawq_pkg::CMD_REL, 255);
		push_req(rawq_pkg::CMD_REQ, 255);
		push_req(rawq_pkg::CMD_REL, 255);
		push_req(rawq_pkg::CMD_REL, 8'hAA);
		push_req(rawq_pkg::CMD_REL, 0);
		push_req(rawq_pkg::CMD_REL, 8'h55);
		push_req(rawq_pkg::CMD_REQ, 255);
		push_req(rawq_pkg::CMD_REL, 255);
		push_req(rawq_pkg::CMD_REQ, 8'h0F);

		// reload while a resource is held, so its return joins a free list that already holds it
		load_count(5'd1);
		push_req(rawq_pkg::CMD_REL, 8'h0F);
		push_req(rawq_pkg::CMD_REQ, 8'hF0);
		push_req(rawq_pkg::CMD_REQ, 8'h33);
		push_req(rawq_pkg::CMD_REL, 8'hF0);
		push_req(rawq_pkg::CMD_REL, 8'h33);

		load_count(5'd31);
		random_phase(PHASE_ITEMS);
		load_count(5'd2);
		random_phase(PHASE_ITEMS);
		load_count(5'd16);
		random_phase(PHASE_ITEMS);
		load_count(5'd1);
		random_phase(PHASE_ITEMS);
		load_count(rawq_pkg::RES_W'($urandom_range(0, 31)));
		random_phase(PHASE_ITEMS);
		load_count(5'd4);
		random_phase(PHASE_ITEMS);
		load_count(rawq_pkg::RES_W'($urandom_range(0, 31)));
		random_phase(PHASE_ITEMS);

		drain_all();
		if (mismatch_count == 0) begin
			$display("resource_allocator_with_wait_queue_top verification clean");
		end else begin
			$display("resource_allocator_with_wait_queue_top verification failed");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/rawq_pkg.sv
hw/rtl/rawq_status_table.sv
hw/rtl/rawq_wait_queue.sv
hw/rtl/rawq_free_list.sv
hw/rtl/resource_allocator_with_wait_queue_top.sv
test/tb_top.sv
